>>> rtl/core/dtx_pkg.sv
package dtx_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;

	localparam logic [2:0] CMD_ENCRYPT   = 3'd0;
	localparam logic [2:0] CMD_DECRYPT   = 3'd1;
	localparam logic [2:0] CMD_REKEY     = 3'd2;
	localparam logic [2:0] CMD_RESET_IDX = 3'd3;
	localparam logic [2:0] CMD_REBUILD   = 3'd4;

	localparam logic [1:0] REG_GEN_ONE   = 2'd0;
	localparam logic [1:0] REG_GEN_TWO   = 2'd1;
	localparam logic [1:0] REG_SWAP_MODE = 2'd2;

	localparam logic [7:0] SWAP_MASK = 8'hAB;

	// one port pair of a keystream table
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [7:0]       wr_data;
	} ram_req_t;

	// exchange nibbles, then whiten
	function automatic logic [7:0] swap_whiten(input logic [7:0] v);
		return {v[3:0], v[7:4]} ^ SWAP_MASK;
	endfunction

endpackage

>>> rtl/core/dual_table_xor_stream_cipher_core.sv
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   cmd, data_byte, key_word, end_of_message
// out      output     out_valid/out_stall result_byte, was_decrypt, end_of_message_out
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// Encrypt and decrypt items: one per cycle while in_stall is low, via stage one
// and the output register. Rekey: one table entry read-modify-written per cycle
// per table. Rebuild: each entry comes from the recurrence (two chained multiplies).
// Index reset zeroes the indexes. After reset a clearing pass zeroes both tables.
// in_stall rises during any table sweep and while a byte waits behind a stalled
// output register.
module dual_table_xor_stream_cipher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [7:0]  data_byte,
	input  logic [31:0] key_word,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  result_byte,
	output logic        was_decrypt,
	output logic        end_of_message_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	import dtx_pkg::*;

	logic       accept;
	logic       data_acc;
	logic       busy;
	logic       xf_hold;
	logic [31:0] gen_one_q;
	logic [31:0] gen_two_q;
	logic       swap_q;
	logic [7:0] rd_one;
	logic [7:0] rd_two;
	ram_req_t   sw_req_one;
	ram_req_t   sw_req_two;
	ram_req_t   xf_req_one;
	ram_req_t   xf_req_two;
	ram_req_t   req_one;
	ram_req_t   req_two;

	// configuration: always ready, masked to register widths
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_one_q <= '0;
			gen_two_q <= '0;
			swap_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GEN_ONE:   gen_one_q <= cfg_data;
				REG_GEN_TWO:   gen_two_q <= cfg_data;
				REG_SWAP_MODE: swap_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// hold the input during sweeps and while a byte is stuck in stage one
	assign in_stall = busy || xf_hold;
	assign accept   = in_valid && !in_stall;
	assign data_acc = accept && (cmd == CMD_ENCRYPT || cmd == CMD_DECRYPT);

	dtx_sweep u_sweep (
		.clk           (clk),
		.arst_n        (arst_n),
		.rekey_go      (accept && (cmd == CMD_REKEY)),
		.build_go      (accept && (cmd == CMD_REBUILD)),
		.key_word      (key_word),
		.generator_one (gen_one_q),
		.generator_two (gen_two_q),
		.rd_data_one   (rd_one),
		.rd_data_two   (rd_two),
		.req_one       (sw_req_one),
		.req_two       (sw_req_two),
		.busy          (busy)
	);

	dtx_xfm u_xfm (
		.clk                (clk),
		.arst_n             (arst_n),
		.data_acc           (data_acc),
		.is_decrypt         (cmd == CMD_DECRYPT),
		.idx_clr            (accept && (cmd == CMD_RESET_IDX)),
		.data_byte          (data_byte),
		.end_of_message     (end_of_message),
		.swap_mode          (swap_q),
		.rd_data_one        (rd_one),
		.rd_data_two        (rd_two),
		.req_one            (xf_req_one),
		.req_two            (xf_req_two),
		.hold               (xf_hold),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.result_byte        (result_byte),
		.was_decrypt        (was_decrypt),
		.end_of_message_out (end_of_message_out)
	);

	// the sequencer owns the tables whenever it is busy
	assign req_one = busy ? sw_req_one : xf_req_one;
	assign req_two = busy ? sw_req_two : xf_req_two;

	dtx_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_table_one (
		.clk     (clk),
		.wr_en   (req_one.wr_en),
		.wr_addr (req_one.wr_addr),
		.wr_data (req_one.wr_data),
		.rd_en   (req_one.rd_en),
		.rd_addr (req_one.rd_addr),
		.rd_data (rd_one)
	);

	dtx_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_table_two (
		.clk     (clk),
		.wr_en   (req_two.wr_en),
		.wr_addr (req_two.wr_addr),
		.wr_data (req_two.wr_data),
		.rd_en   (req_two.rd_en),
		.rd_addr (req_two.rd_addr),
		.rd_data (rd_two)
	);

	// a rekey or rebuild item must start a sweep on the next cycle
	a_sweep_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd == CMD_REKEY || cmd == CMD_REBUILD) |=> busy)
		else $error("sweep did not start");

	// no byte lookup may reach the tables during a sweep
	a_no_lookup_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !xf_req_one.rd_en && !xf_req_two.rd_en)
		else $error("lookup issued during sweep");

	// a fresh result must come from a byte that sat in stage one
	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid && out_stall) |-> $past(xf_hold || u_xfm.valid_s1))
		else $error("result without a byte behind it");

endmodule

>>> rtl/core/dtx_ram.sv
module dtx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/core/dtx_sweep.sv
module dtx_sweep (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rekey_go,
	input  logic              build_go,
	input  logic [31:0]       key_word,
	input  logic [31:0]       generator_one,
	input  logic [31:0]       generator_two,
	input  logic [7:0]        rd_data_one,
	input  logic [7:0]        rd_data_two,
	output dtx_pkg::ram_req_t req_one,
	output dtx_pkg::ram_req_t req_two,
	output logic              busy
);

	import dtx_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CLEAR = 4'b0010,
		ST_REKEY = 4'b0100,
		ST_BUILD = 4'b1000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             phase_q;
	logic [31:0]      key_q;
	logic [31:0]      key2_q;
	logic [31:0]      gen1_q;
	logic [31:0]      gen2_q;
	logic [7:0]       n1_q;
	logic [7:0]       n2_q;
	logic [7:0]       t1_q;
	logic [7:0]       t2_q;
	logic [IDX_W-1:0] wb_addr;
	logic             last_entry;

	assign busy       = (state_q != ST_IDLE);
	assign wb_addr    = cnt_q[IDX_W-1:0] - IDX_W'(1);
	assign last_entry = (cnt_q[IDX_W-1:0] == {IDX_W{1'b1}});

	always_comb begin
		req_one = '0;
		req_two = '0;
		unique case (state_q)
			ST_CLEAR: begin
				req_one.wr_en   = 1'b1;
				req_one.wr_addr = cnt_q[IDX_W-1:0];
				req_two.wr_en   = 1'b1;
				req_two.wr_addr = cnt_q[IDX_W-1:0];
			end
			ST_REKEY: begin
				// read entry k while writing back entry k-1
				req_one.rd_en   = !cnt_q[IDX_W];
				req_one.rd_addr = cnt_q[IDX_W-1:0];
				req_two.rd_en   = !cnt_q[IDX_W];
				req_two.rd_addr = cnt_q[IDX_W-1:0];
				req_one.wr_en   = (cnt_q != '0);
				req_one.wr_addr = wb_addr;
				req_one.wr_data = rd_data_one ^ key_q[{wb_addr[1:0], 3'b000} +: 8];
				req_two.wr_en   = (cnt_q != '0);
				req_two.wr_addr = wb_addr;
				req_two.wr_data = rd_data_two ^ key2_q[{wb_addr[1:0], 3'b000} +: 8];
			end
			ST_BUILD: begin
				req_one.wr_en   = phase_q;
				req_one.wr_addr = cnt_q[IDX_W-1:0];
				req_one.wr_data = n1_q;
				req_two.wr_en   = phase_q;
				req_two.wr_addr = cnt_q[IDX_W-1:0];
				req_two.wr_data = n2_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			phase_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q   <= '0;
					phase_q <= 1'b0;
					if (rekey_go) begin
						state_q <= ST_REKEY;
					end else if (build_go) begin
						state_q <= ST_BUILD;
					end
				end
				ST_CLEAR: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (last_entry) begin
						state_q <= ST_IDLE;
					end
				end
				ST_REKEY: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q[IDX_W]) begin
						state_q <= ST_IDLE;
					end
				end
				ST_BUILD: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (last_entry) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// recurrence in two steps: t = a*n + b, then n' = t*n + c
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			if (rekey_go) begin
				key_q  <= key_word;
				key2_q <= key_word * key_word;
			end
			if (build_go) begin
				gen1_q <= generator_one;
				gen2_q <= generator_two;
				n1_q   <= generator_one[31:24];
				n2_q   <= generator_two[31:24];
			end
		end else if (state_q == ST_BUILD) begin
			if (!phase_q) begin
				t1_q <= gen1_q[7:0] * n1_q + gen1_q[15:8];
				t2_q <= gen2_q[7:0] * n2_q + gen2_q[15:8];
			end else begin
				n1_q <= t1_q * n1_q + gen1_q[23:16];
				n2_q <= t2_q * n2_q + gen2_q[23:16];
			end
		end
	end

endmodule

>>> rtl/core/dtx_xfm.sv
module dtx_xfm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              data_acc,
	input  logic              is_decrypt,
	input  logic              idx_clr,
	input  logic [7:0]        data_byte,
	input  logic              end_of_message,
	input  logic              swap_mode,
	input  logic [7:0]        rd_data_one,
	input  logic [7:0]        rd_data_two,
	output dtx_pkg::ram_req_t req_one,
	output dtx_pkg::ram_req_t req_two,
	output logic              hold,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        result_byte,
	output logic              was_decrypt,
	output logic              end_of_message_out
);

	import dtx_pkg::*;

	logic [IDX_W-1:0] enc_lo_q;
	logic [IDX_W-1:0] enc_hi_q;
	logic [IDX_W-1:0] dec_lo_q;
	logic [IDX_W-1:0] dec_hi_q;
	logic [IDX_W-1:0] lo;
	logic [IDX_W-1:0] hi;
	logic [IDX_W-1:0] lo_next;
	logic [IDX_W-1:0] hi_next;
	logic             valid_s1;
	logic [7:0]       data_s1;
	logic             dec_s1;
	logic             eom_s1;
	logic             out_valid_q;
	logic             advance;
	logic [7:0]       mixed;

	assign lo      = is_decrypt ? dec_lo_q : enc_lo_q;
	assign hi      = is_decrypt ? dec_hi_q : enc_hi_q;
	assign lo_next = lo + IDX_W'(1);
	assign hi_next = (lo_next == '0) ? hi + IDX_W'(1) : hi;

	always_comb begin
		req_one         = '0;
		req_two         = '0;
		req_one.rd_en   = data_acc;
		req_one.rd_addr = lo;
		req_two.rd_en   = data_acc;
		req_two.rd_addr = hi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_lo_q <= '0;
			enc_hi_q <= '0;
			dec_lo_q <= '0;
			dec_hi_q <= '0;
		end else if (idx_clr) begin
			enc_lo_q <= '0;
			enc_hi_q <= '0;
			dec_lo_q <= '0;
			dec_hi_q <= '0;
		end else if (data_acc) begin
			if (is_decrypt) begin
				dec_lo_q <= lo_next;
				dec_hi_q <= hi_next;
			end else begin
				enc_lo_q <= lo_next;
				enc_hi_q <= hi_next;
			end
		end
	end

	assign advance = !out_valid_q || !out_stall;
	assign hold    = valid_s1 && !advance;
	assign mixed   = data_s1 ^ rd_data_one ^ rd_data_two;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (data_acc) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (data_acc) begin
			data_s1 <= data_byte;
			dec_s1  <= is_decrypt;
			eom_s1  <= end_of_message;
		end
		if (valid_s1 && advance) begin
			result_byte        <= swap_mode ? swap_whiten(mixed) : mixed;
			was_decrypt        <= dec_s1;
			end_of_message_out <= eom_s1;
		end
	end

	assign out_valid = out_valid_q;

endmodule
